// ----- hw/rtl/hslrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared constants and types for the HSL to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

   localparam int HUE_BITS_DEF = 12;
   localparam int SL_BITS      = 9;
   localparam int CH_BITS      = 8;
   localparam int QP_BITS      = 17;
   localparam int N_STAGES     = 4;

   localparam logic [SL_BITS-1:0] SL_FULL    = 9'd256;
   localparam logic [SL_BITS-1:0] LIGHT_HALF = 9'd128;
   localparam logic [CH_BITS-1:0] CH_MAX     = 8'd255;

   // load enables, one per pipeline stage
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

// ----- hw/rtl/hslrgb_qp.sv -----
// ----------------------------------------------------------------------------
// hslrgb_qp
// Stages 1 and 2: clamps saturation and lightness, forms p and q - p.
// ----------------------------------------------------------------------------
module hslrgb_qp (
   input  logic                                 clock,
   input  hslrgb_pkg::stage_en_type             en,
   input  logic [hslrgb_pkg::SL_BITS-1:0]       saturation,
   input  logic [hslrgb_pkg::SL_BITS-1:0]       lightness,
   output logic [hslrgb_pkg::QP_BITS-1:0]       p_out,
   output logic [hslrgb_pkg::QP_BITS-1:0]       d_out
);

   localparam int SLW = hslrgb_pkg::SL_BITS;
   localparam int QPW = hslrgb_pkg::QP_BITS;
   localparam int AW  = QPW + 1;

   logic [SLW-1:0]   s_in, l_in, s_ff, l_ff;
   logic [2*SLW-1:0] ls_in, ls_ff;
   logic [AW-1:0]    q_calc, p_calc, d_calc;
   logic [QPW-1:0]   p_ff, d_ff;

   always_comb begin
      s_in  = (saturation > hslrgb_pkg::SL_FULL) ? hslrgb_pkg::SL_FULL : saturation;
      l_in  = (lightness  > hslrgb_pkg::SL_FULL) ? hslrgb_pkg::SL_FULL : lightness;
      ls_in = (2*SLW)'(l_in) * (2*SLW)'(s_in);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         s_ff  <= s_in;
         l_ff  <= l_in;
         ls_ff <= ls_in;
      end
   end

   always_comb begin
      if (l_ff < hslrgb_pkg::LIGHT_HALF) begin
         q_calc = (AW'(l_ff) << 8) + AW'(ls_ff);
      end else begin
         q_calc = (AW'(l_ff) << 8) + (AW'(s_ff) << 8) - AW'(ls_ff);
      end
      p_calc = (AW'(l_ff) << 9) - q_calc;
      d_calc = q_calc - p_calc;
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         p_ff <= p_calc[QPW-1:0];
         d_ff <= d_calc[QPW-1:0];
      end
   end

   assign p_out = p_ff;
   assign d_out = d_ff;

endmodule

// ----- hw/rtl/hslrgb_hue.sv -----
// ----------------------------------------------------------------------------
// hslrgb_hue
// Stages 1 and 2: per-channel hue offsets in thirds of a turn, then the
// piecewise weight that stage 3 applies to q - p.
// ----------------------------------------------------------------------------
module hslrgb_hue #(
   parameter int HUE_BITS = hslrgb_pkg::HUE_BITS_DEF
) (
   input  logic                clock,
   input  hslrgb_pkg::stage_en_type en,
   input  logic [HUE_BITS-1:0] hue,
   output logic [HUE_BITS:0]   f_red,
   output logic [HUE_BITS:0]   f_green,
   output logic [HUE_BITS:0]   f_blue
);

   localparam int TW = HUE_BITS + 2;
   localparam int FW = HUE_BITS + 1;

   localparam logic [TW:0]   TURN_X   = (TW+1)'(1) << HUE_BITS;
   localparam logic [TW:0]   TURN3_X  = TURN_X + (TURN_X << 1);
   localparam logic [TW-1:0] T_HALF   = TW'(1) << (HUE_BITS - 1);
   localparam logic [TW-1:0] T_ONEP5  = (TW'(3)) << (HUE_BITS - 1);
   localparam logic [TW-1:0] T_TWO    = TW'(1) << (HUE_BITS + 1);
   localparam logic [FW-1:0] F_FULL   = FW'(1) << HUE_BITS;

   logic [TW-1:0] h3;
   logic [TW:0]   tr_sum, tb_sum;
   logic [TW-1:0] tr_in, tb_in;
   logic [TW-1:0] tr_ff, tg_ff, tb_ff;
   logic [FW-1:0] fr_ff, fg_ff, fb_ff;

   function automatic logic [FW-1:0] weight_of(input logic [TW-1:0] t);
      logic [TW-1:0] diff;
      diff = T_TWO - t;
      if (t < T_HALF) begin
         weight_of = FW'({t, 1'b0});
      end else if (t < T_ONEP5) begin
         weight_of = F_FULL;
      end else if (t < T_TWO) begin
         weight_of = FW'({diff, 1'b0});
      end else begin
         weight_of = '0;
      end
   endfunction

   always_comb begin
      h3     = TW'(hue) + (TW'(hue) << 1);
      tr_sum = (TW+1)'(h3) + TURN_X;
      tb_sum = (TW+1)'(h3) + (TURN_X << 1);
      tr_in  = (tr_sum >= TURN3_X) ? TW'(tr_sum - TURN3_X) : tr_sum[TW-1:0];
      tb_in  = (tb_sum >= TURN3_X) ? TW'(tb_sum - TURN3_X) : tb_sum[TW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         tr_ff <= tr_in;
         tg_ff <= h3;
         tb_ff <= tb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         fr_ff <= weight_of(tr_ff);
         fg_ff <= weight_of(tg_ff);
         fb_ff <= weight_of(tb_ff);
      end
   end

   assign f_red   = fr_ff;
   assign f_green = fg_ff;
   assign f_blue  = fb_ff;

endmodule

// ----- hw/rtl/hslrgb_chan.sv -----
// ----------------------------------------------------------------------------
// hslrgb_chan
// Stages 3 and 4 of one channel: (q - p) * weight, then p added, scaled by
// 255, truncated and clamped.
// ----------------------------------------------------------------------------
module hslrgb_chan #(
   parameter int HUE_BITS = hslrgb_pkg::HUE_BITS_DEF
) (
   input  logic                                clock,
   input  hslrgb_pkg::stage_en_type            en,
   input  logic [hslrgb_pkg::QP_BITS-1:0]      p_in,
   input  logic [hslrgb_pkg::QP_BITS-1:0]      d_in,
   input  logic [HUE_BITS:0]                   f_in,
   output logic [hslrgb_pkg::CH_BITS-1:0]      level
);

   localparam int QPW = hslrgb_pkg::QP_BITS;
   localparam int CHW = hslrgb_pkg::CH_BITS;
   localparam int PW  = QPW + HUE_BITS + 1;
   localparam int SW  = PW + 8;
   localparam int SH  = 16 + HUE_BITS;

   logic [QPW-1:0] p_ff;
   logic [PW-1:0]  prod_ff, num;
   logic [SW-1:0]  scaled;
   logic [SW-SH-1:0] v;
   logic [CHW-1:0] level_in, level_ff;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         p_ff    <= p_in;
         prod_ff <= PW'(d_in) * PW'(f_in);
      end
   end

   always_comb begin
      num      = (PW'(p_ff) << HUE_BITS) + prod_ff;
      scaled   = {num, 8'b0} - SW'(num);
      v        = scaled[SW-1:SH];
      level_in = (v > (SW-SH)'(hslrgb_pkg::CH_MAX)) ? hslrgb_pkg::CH_MAX : v[CHW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

// ----- hw/rtl/hsl_to_rgb_converter_unit.sv -----
// Pipeline: a request passes stages 1 to 4 in order; rsp_tvalid rises once it
// reaches stage 4, and it is held there until rsp_tready takes it.
// Throughput: one request per cycle unless rsp_tready stalls; four register
// stages with a valid bit each; an empty stage fills while a later one stalls.
// Reset: synchronous, clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit
// Streams hue, saturation and lightness in and 8-bit red, green, blue out.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_unit #(
   parameter int HUE_BITS = hslrgb_pkg::HUE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // hue [HUE_BITS], saturation [9], lightness [9], zero pad to bytes
   input  logic [((HUE_BITS + 2*hslrgb_pkg::SL_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // red [8], green [8], blue [8]
   output logic [3*hslrgb_pkg::CH_BITS-1:0] rsp_tdata
);

   localparam int SLW = hslrgb_pkg::SL_BITS;
   localparam int NS  = hslrgb_pkg::N_STAGES;
   localparam int CHW = hslrgb_pkg::CH_BITS;

   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] adv;
   hslrgb_pkg::stage_en_type en;

   logic [HUE_BITS-1:0] hue;
   logic [SLW-1:0]      saturation, lightness;
   logic [hslrgb_pkg::QP_BITS-1:0] p_w, d_w;
   logic [HUE_BITS:0]   f_red, f_green, f_blue;
   logic [CHW-1:0]      red, green, blue;

   assign hue        = req_tdata[HUE_BITS-1:0];
   assign saturation = req_tdata[HUE_BITS+SLW-1:HUE_BITS];
   assign lightness  = req_tdata[HUE_BITS+2*SLW-1:HUE_BITS+SLW];

   always_comb begin
      adv[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < NS; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
      en.s1 = adv[0];
      en.s2 = adv[1];
      en.s3 = adv[2];
      en.s4 = adv[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   hslrgb_qp u_qp (
      .clock      (clock),
      .en         (en),
      .saturation (saturation),
      .lightness  (lightness),
      .p_out      (p_w),
      .d_out      (d_w)
   );

   hslrgb_hue #(.HUE_BITS(HUE_BITS)) u_hue (
      .clock   (clock),
      .en      (en),
      .hue     (hue),
      .f_red   (f_red),
      .f_green (f_green),
      .f_blue  (f_blue)
   );

   hslrgb_chan #(.HUE_BITS(HUE_BITS)) u_red (
      .clock (clock), .en (en), .p_in (p_w), .d_in (d_w), .f_in (f_red), .level (red)
   );

   hslrgb_chan #(.HUE_BITS(HUE_BITS)) u_green (
      .clock (clock), .en (en), .p_in (p_w), .d_in (d_w), .f_in (f_green), .level (green)
   );

   hslrgb_chan #(.HUE_BITS(HUE_BITS)) u_blue (
      .clock (clock), .en (en), .p_in (p_w), .d_in (d_w), .f_in (f_blue), .level (blue)
   );

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = {blue, green, red};

   a_reset_clears : assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("valid bits not cleared by reset");

   a_full_blocks : assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipeline full and stalled");

   a_out_holds : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NS-1] && !rsp_tready) |=> (valid_ff[NS-1] && $stable(rsp_tdata)))
      else $error("output stage changed while stalled");

endmodule

// ----- tb/hsl_to_rgb_converter_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit_tb
// Drives hue, saturation and lightness requests through the converter with
// random gaps and back-pressure, and checks each red, green, blue result in
// order against a typed value or an exact integer predictor. A directed
// table covers the grey, black, white and pure-red extremes, clamping of
// out-of-range saturation and lightness, and the hue sector boundaries;
// random requests follow.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_unit_tb;

   localparam int HUE_W   = hslrgb_pkg::HUE_BITS_DEF;
   localparam int REQ_W   = ((HUE_W + 2*hslrgb_pkg::SL_BITS + 7) / 8) * 8;
   localparam int RSP_W   = 3*hslrgb_pkg::CH_BITS;
   localparam int N_DIR   = 24;
   localparam int N_RAND  = 450;
   localparam int HOLD_AT = 60;
   localparam int HOLD_CY = 40;

   typedef struct packed {
      logic [hslrgb_pkg::CH_BITS-1:0] red;
      logic [hslrgb_pkg::CH_BITS-1:0] green;
      logic [hslrgb_pkg::CH_BITS-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [HUE_W-1:0]               hue;
      logic [hslrgb_pkg::SL_BITS-1:0] sat;
      logic [hslrgb_pkg::SL_BITS-1:0] light;
      logic                           typed;
      rgb_type                        rgb;
   } colour_case_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata   = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   logic             req_typed     = 1'b0;
   rgb_type          req_typed_rgb = '0;
   bit               rx_quiet      = 1'b0;
   int               n_accepted    = 0;
   int               n_mismatch    = 0;
   rgb_type          rgb_expected [$];

   // typed rows: greys, black, white, pure red, clamped inputs
   colour_case_type directed_cases [0:N_DIR-1] = '{
      '{12'd0,    9'd0,   9'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{12'd4095, 9'd0,   9'd256, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{12'd0,    9'd0,   9'd128, 1'b1, '{8'd127, 8'd127, 8'd127}},
      '{12'd2048, 9'd0,   9'd255, 1'b1, '{8'd254, 8'd254, 8'd254}},
      '{12'd0,    9'd256, 9'd128, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{12'd0,    9'd256, 9'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{12'd0,    9'd256, 9'd256, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{12'd0,    9'd511, 9'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{12'd1234, 9'd511, 9'd256, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{12'd0,    9'd0,   9'd511, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{12'd4095, 9'd511, 9'd511, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{12'd4095, 9'd256, 9'd128, 1'b0, '0},
      '{12'd682,  9'd256, 9'd128, 1'b0, '0},
      '{12'd683,  9'd256, 9'd128, 1'b0, '0},
      '{12'd1365, 9'd200, 9'd100, 1'b0, '0},
      '{12'd1366, 9'd200, 9'd100, 1'b0, '0},
      '{12'd2048, 9'd180, 9'd180, 1'b0, '0},
      '{12'd2730, 9'd180, 9'd180, 1'b0, '0},
      '{12'd2731, 9'd180, 9'd180, 1'b0, '0},
      '{12'd3413, 9'd256, 9'd64,  1'b0, '0},
      '{12'd100,  9'd200, 9'd127, 1'b0, '0},
      '{12'd100,  9'd200, 9'd128, 1'b0, '0},
      '{12'd3000, 9'd257, 9'd100, 1'b0, '0},
      '{12'd3000, 9'd100, 9'd257, 1'b0, '0}
   };

   hsl_to_rgb_converter_unit #(
      .HUE_BITS(HUE_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // one channel from the hue position t3, in units of 1/(3*turn)
   function automatic logic [hslrgb_pkg::CH_BITS-1:0] channel_level(
      input longint unsigned p,
      input longint unsigned q,
      input longint unsigned t3,
      input longint unsigned turn
   );
      longint unsigned d;
      longint unsigned num;
      longint unsigned v;
      d = q - p;
      if (2*t3 < turn) begin
         num = p*turn + d*2*t3;
      end else if (2*t3 < 3*turn) begin
         num = q*turn;
      end else if (t3 < 2*turn) begin
         num = p*turn + d*2*(2*turn - t3);
      end else begin
         num = p*turn;
      end
      v = (num * 255) / (65536 * turn);
      if (v > 255) begin
         v = 255;
      end
      return v[hslrgb_pkg::CH_BITS-1:0];
   endfunction

   function automatic rgb_type predict_rgb(
      input logic [HUE_W-1:0]               hue,
      input logic [hslrgb_pkg::SL_BITS-1:0] sat_in,
      input logic [hslrgb_pkg::SL_BITS-1:0] light_in
   );
      longint unsigned turn;
      longint unsigned s;
      longint unsigned l;
      longint unsigned q;
      longint unsigned p;
      longint unsigned h3;
      longint unsigned t_red;
      longint unsigned t_blue;
      rgb_type c;
      turn = longint'(1) << HUE_W;
      s = (sat_in > hslrgb_pkg::SL_FULL) ? 256 : sat_in;
      l = (light_in > hslrgb_pkg::SL_FULL) ? 256 : light_in;
      if (l < 128) begin
         q = l * (256 + s);
      end else begin
         q = l*256 + s*256 - l*s;
      end
      p = 512*l - q;
      h3 = 3 * longint'(hue);
      t_red = h3 + turn;
      if (t_red >= 3*turn) begin
         t_red -= 3*turn;
      end
      t_blue = h3 + 2*turn;
      if (t_blue >= 3*turn) begin
         t_blue -= 3*turn;
      end
      c.red   = channel_level(p, q, t_red, turn);
      c.green = channel_level(p, q, h3, turn);
      c.blue  = channel_level(p, q, t_blue, turn);
      return c;
   endfunction

   function automatic logic [hslrgb_pkg::SL_BITS-1:0] random_level();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return hslrgb_pkg::SL_BITS'($urandom_range(257, 511));
      end else if (pick == 1) begin
         return ($urandom_range(0, 1) == 1) ? 9'd256 : 9'd0;
      end else if (pick == 2) begin
         return hslrgb_pkg::SL_BITS'($urandom_range(124, 132));
      end
      return hslrgb_pkg::SL_BITS'($urandom_range(0, 256));
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic offer_colour(
      input logic [HUE_W-1:0]               hue,
      input logic [hslrgb_pkg::SL_BITS-1:0] sat,
      input logic [hslrgb_pkg::SL_BITS-1:0] light,
      input logic                           typed,
      input rgb_type                        typed_rgb,
      input bit                             idle_ok
   );
      int gap;
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= REQ_W'({light, sat, hue});
      req_typed     <= typed;
      req_typed_rgb <= typed_rgb;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // request side
   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIR; i++) begin
         offer_colour(directed_cases[i].hue, directed_cases[i].sat,
                      directed_cases[i].light, directed_cases[i].typed,
                      directed_cases[i].rgb, 1'b1);
      end
      for (int i = 0; i < N_RAND; i++) begin
         rx_quiet = (i >= 200 && i < 260) || (i >= N_RAND - 100);
         offer_colour(HUE_W'($urandom_range(0, (1 << HUE_W) - 1)), random_level(),
                      random_level(), 1'b0, '0, !rx_quiet);
      end
      req_tvalid <= 1'b0;
      while (rgb_expected.size() != 0) @(posedge clock);
      repeat (3*hslrgb_pkg::N_STAGES + 4) @(posedge clock);
      if (n_mismatch == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // result side: random stalls plus one long hold to back up the pipeline
   initial begin
      bit   held;
      int   stall;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(negedge clock);
         if (!held && n_accepted >= HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CY) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 11);
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rgb_type want;
      rgb_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            n_accepted++;
            if (req_typed) begin
               rgb_expected.push_back(req_typed_rgb);
            end else begin
               rgb_expected.push_back(predict_rgb(
                  req_tdata[HUE_W-1:0],
                  req_tdata[HUE_W +: hslrgb_pkg::SL_BITS],
                  req_tdata[HUE_W+hslrgb_pkg::SL_BITS +: hslrgb_pkg::SL_BITS]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.red   = rsp_tdata[0 +: hslrgb_pkg::CH_BITS];
            got.green = rsp_tdata[hslrgb_pkg::CH_BITS +: hslrgb_pkg::CH_BITS];
            got.blue  = rsp_tdata[2*hslrgb_pkg::CH_BITS +: hslrgb_pkg::CH_BITS];
            if (rgb_expected.size() == 0) begin
               $error("result with no request outstanding: %h", rsp_tdata);
               n_mismatch++;
            end else begin
               want = rgb_expected.pop_front();
               if (got.red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, got.red);
                  n_mismatch++;
               end
               if (got.green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, got.green);
                  n_mismatch++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, got.blue);
                  n_mismatch++;
               end
            end
         end
      end
   end

   initial begin
      #(1_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
